FILE: src/gcd_pkg.sv
// -----------------------------------------------------------------------------
// gcd_pkg
// Shared widths, register indexes and the reciprocal table used to divide a
// corner sum by the inner value count.
// -----------------------------------------------------------------------------
package gcd_pkg;

   // Field widths
   localparam int VALUE_W     = 16;
   localparam int AMOUNT_W    = 24;
   localparam int NUMBER_W    = 3;
   localparam int CORNER_CFG_W = 4;
   localparam int INNER_CFG_W  = 3;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;
   localparam logic [CSR_INDEX_W-1:0] REG_CORNER_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_INNER_COUNT  = 2'd1;

   // Reset values of the registers
   localparam logic [CORNER_CFG_W-1:0] CORNER_COUNT_RESET = 4'd8;
   localparam logic [INNER_CFG_W-1:0]  INNER_COUNT_RESET  = 3'd6;

   // Reciprocal scaling: floor(sum / d) ~= (sum * floor(2^20 / d)) >> 20,
   // low by at most one for sums below 2^19
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_W     = 21;

   function automatic logic [RECIP_W-1:0] recip(input logic [INNER_CFG_W-1:0] d);
      logic [RECIP_W-1:0] r;
      case (d)
         3'd2:    r = 21'd524288;
         3'd3:    r = 21'd349525;
         3'd4:    r = 21'd262144;
         3'd5:    r = 21'd209715;
         3'd6:    r = 21'd174762;
         default: r = 21'd1048576;
      endcase
      return r;
   endfunction

endpackage

FILE: src/gcd_average.sv
// -----------------------------------------------------------------------------
// gcd_average
// Three-stage averaging unit: sums the first ni values of a corner row,
// multiplies by the reciprocal of ni, then corrects the quotient by one.
// -----------------------------------------------------------------------------
module gcd_average #(
   parameter int MAX_INNER = 6
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           start,
   input  logic [MAX_INNER-1:0][gcd_pkg::VALUE_W-1:0]     row,
   input  logic [gcd_pkg::INNER_CFG_W-1:0]                ni,
   output logic                                           done,
   output logic [gcd_pkg::VALUE_W-1:0]                    average
);

   localparam int SUM_W  = gcd_pkg::VALUE_W + $clog2(MAX_INNER);
   localparam int PROD_W = SUM_W + gcd_pkg::RECIP_W;
   localparam int QN_W   = SUM_W + gcd_pkg::INNER_CFG_W;

   logic                               v1_ff, v2_ff, done_ff;
   logic [SUM_W-1:0]                   sum1_ff, sum2_ff;
   logic [gcd_pkg::INNER_CFG_W-1:0]    ni1_ff, ni2_ff;
   logic [PROD_W-1:0]                  prod_ff;
   logic [gcd_pkg::VALUE_W-1:0]        average_ff;

   logic [SUM_W-1:0]                   sum_in;
   logic [SUM_W-1:0]                   q0;
   logic [QN_W-1:0]                    qn;
   logic [QN_W-1:0]                    rem;
   logic [SUM_W-1:0]                   q_fix;

   // Masked sum of the active inner values
   always_comb begin
      sum_in = '0;
      for (int j = 0; j < MAX_INNER; j++) begin
         if (j < int'(ni)) begin
            sum_in = sum_in + SUM_W'(row[j]);
         end
      end
   end

   // Quotient correction: remainder of the estimate reaches ni at most once
   always_comb begin
      q0    = prod_ff[gcd_pkg::RECIP_SHIFT +: SUM_W];
      qn    = QN_W'(q0) * QN_W'(ni2_ff);
      rem   = QN_W'(sum2_ff) - qn;
      q_fix = (rem >= QN_W'(ni2_ff)) ? q0 + SUM_W'(1) : q0;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= start;
         v2_ff   <= v1_ff;
         done_ff <= v2_ff;
      end
   end

   // Datapath stages
   always_ff @(posedge clock) begin
      sum1_ff    <= sum_in;
      ni1_ff     <= ni;
      prod_ff    <= PROD_W'(sum1_ff) * PROD_W'(gcd_pkg::recip(ni1_ff));
      sum2_ff    <= sum1_ff;
      ni2_ff     <= ni1_ff;
      average_ff <= q_fix[gcd_pkg::VALUE_W-1:0];
   end

   assign done    = done_ff;
   assign average = average_ff;

endmodule

FILE: src/greedy_corner_decrement.sv
// -----------------------------------------------------------------------------
// greedy_corner_decrement
// A cell arrives as one item per corner; each item is taken while the unit
// is idle and its inner values are written to a row memory. The final corner
// item starts the sharing: each corner's row is read and averaged in turn
// through one shared averaging unit, then the greedy choice scans the corner
// averages one per cycle through a single comparator, with a grant step after
// each scan, and repeats until the amount is used up or no corner qualifies.
// One result per corner then follows, one per cycle while rsp_stall is low.
// With k corners chosen there are k search passes when the amount runs out,
// k+1 when it does not, and none when the amount is zero. The input is
// stalled throughout. Configuration writes are always ready, and a write to
// either register restarts the cell load.
// -----------------------------------------------------------------------------
module greedy_corner_decrement #(
   parameter int MAX_CORNERS = 8,
   parameter int MAX_INNER   = 6
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input items
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [gcd_pkg::VALUE_W-1:0]           req_value_0,
   input  logic [gcd_pkg::VALUE_W-1:0]           req_value_1,
   input  logic [gcd_pkg::VALUE_W-1:0]           req_value_2,
   input  logic [gcd_pkg::VALUE_W-1:0]           req_value_3,
   input  logic [gcd_pkg::VALUE_W-1:0]           req_value_4,
   input  logic [gcd_pkg::VALUE_W-1:0]           req_value_5,
   input  logic [gcd_pkg::AMOUNT_W-1:0]          req_cell_amount,
   // result items
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [gcd_pkg::NUMBER_W-1:0]          rsp_corner_number,
   output logic [gcd_pkg::VALUE_W-1:0]           rsp_corner_delta,
   output logic                                  rsp_last,
   // configuration writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [gcd_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [gcd_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int CI_W  = $clog2(MAX_CORNERS);
   localparam int ROW_W = MAX_INNER * gcd_pkg::VALUE_W;
   localparam int CC_W  = gcd_pkg::CORNER_CFG_W;
   localparam int IC_W  = gcd_pkg::INNER_CFG_W;
   localparam int VW    = gcd_pkg::VALUE_W;
   localparam int AW    = gcd_pkg::AMOUNT_W;

   // Sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_AVG   = 3'd2;
   localparam logic [2:0] S_WAIT  = 3'd3;
   localparam logic [2:0] S_SCAN  = 3'd4;
   localparam logic [2:0] S_GRANT = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0]                          state_ff, state_in;
   logic [CC_W-1:0]                     corner_count_ff, corner_count_in;
   logic [IC_W-1:0]                     inner_count_ff, inner_count_in;
   logic [CC_W-1:0]                     load_cnt_ff, load_cnt_in;
   logic [CI_W-1:0]                     idx_ff, idx_in;
   logic [AW-1:0]                       remain_ff, remain_in;
   logic [VW-1:0]                       best_ff, best_in;
   logic [CI_W-1:0]                     pick_ff, pick_in;
   logic                                found_ff, found_in;
   logic [MAX_CORNERS-1:0][VW-1:0]      avg_ff, avg_in;
   logic [MAX_CORNERS-1:0][VW-1:0]      delta_ff, delta_in;
   logic [MAX_CORNERS-1:0]              chosen_ff, chosen_in;

   // Row memory, one row of inner values per corner
   logic [ROW_W-1:0]                    row_mem [MAX_CORNERS];
   logic [ROW_W-1:0]                    rd_data_ff;

   logic [CC_W-1:0]                     nc;
   logic [IC_W-1:0]                     ni;
   logic [CI_W-1:0]                     slot;
   logic [CC_W-1:0]                     slot_next;
   logic                                idx_last;
   logic                                req_take;
   logic                                csr_take;
   logic [5:0][VW-1:0]                  in_vals;
   logic [MAX_INNER-1:0][VW-1:0]        in_row;
   logic [VW-1:0]                       cand;
   logic                                cand_ok;
   logic                                avg_start;
   logic                                avg_done;
   logic [VW-1:0]                       avg_q;

   // Clamped configuration
   always_comb begin
      if (corner_count_ff < CC_W'(4)) begin
         nc = CC_W'(4);
      end else if (corner_count_ff > CC_W'(MAX_CORNERS)) begin
         nc = CC_W'(MAX_CORNERS);
      end else begin
         nc = corner_count_ff;
      end
      if (inner_count_ff == '0) begin
         ni = IC_W'(1);
      end else if (inner_count_ff > IC_W'(MAX_INNER)) begin
         ni = IC_W'(MAX_INNER);
      end else begin
         ni = inner_count_ff;
      end
   end

   // Handshakes and load slot
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;
   assign slot      = (load_cnt_ff >= nc) ? '0 : load_cnt_ff[CI_W-1:0];
   assign slot_next = CC_W'(slot) + CC_W'(1);
   assign idx_last  = (CC_W'(idx_ff) + CC_W'(1)) == nc;

   always_comb begin
      in_vals = {req_value_5, req_value_4, req_value_3,
                 req_value_2, req_value_1, req_value_0};
      for (int j = 0; j < MAX_INNER; j++) begin
         in_row[j] = in_vals[j];
      end
   end

   // Row write on each item, registered read at the scan index
   always_ff @(posedge clock) begin
      if (req_take) begin
         row_mem[slot] <= in_row;
      end
      rd_data_ff <= row_mem[idx_ff];
   end

   // Shared averaging unit
   assign avg_start = (state_ff == S_AVG);

   gcd_average #(
      .MAX_INNER (MAX_INNER)
   ) u_average (
      .clock   (clock),
      .reset   (reset),
      .start   (avg_start),
      .row     (rd_data_ff),
      .ni      (ni),
      .done    (avg_done),
      .average (avg_q)
   );

   // Candidate test for the minimum search
   assign cand    = avg_ff[idx_ff];
   assign cand_ok = (cand != '0) && !chosen_ff[idx_ff] && (!found_ff || cand < best_ff);

   // Sequencer
   always_comb begin
      state_in        = state_ff;
      corner_count_in = corner_count_ff;
      inner_count_in  = inner_count_ff;
      load_cnt_in     = load_cnt_ff;
      idx_in          = idx_ff;
      remain_in       = remain_ff;
      best_in         = best_ff;
      pick_in         = pick_ff;
      found_in        = found_ff;
      avg_in          = avg_ff;
      delta_in        = delta_ff;
      chosen_in       = chosen_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (slot_next == nc) begin
                  load_cnt_in = '0;
                  remain_in   = req_cell_amount;
                  delta_in    = '0;
                  chosen_in   = '0;
                  idx_in      = '0;
                  state_in    = S_READ;
               end else begin
                  load_cnt_in = slot_next;
               end
            end
         end
         S_READ: begin
            state_in = S_AVG;
         end
         S_AVG: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (avg_done) begin
               avg_in[idx_ff] = avg_q;
               if (idx_last) begin
                  idx_in   = '0;
                  found_in = 1'b0;
                  state_in = (remain_ff != '0) ? S_SCAN : S_OUT;
               end else begin
                  idx_in   = idx_ff + CI_W'(1);
                  state_in = S_READ;
               end
            end
         end
         S_SCAN: begin
            if (cand_ok) begin
               best_in  = cand;
               pick_in  = idx_ff;
               found_in = 1'b1;
            end
            if (idx_last) begin
               idx_in   = '0;
               state_in = S_GRANT;
            end else begin
               idx_in = idx_ff + CI_W'(1);
            end
         end
         S_GRANT: begin
            if (!found_ff) begin
               state_in = S_OUT;
            end else begin
               chosen_in[pick_ff] = 1'b1;
               found_in           = 1'b0;
               if (remain_ff < AW'(best_ff)) begin
                  delta_in[pick_ff] = remain_ff[VW-1:0];
                  remain_in         = '0;
                  state_in          = S_OUT;
               end else begin
                  delta_in[pick_ff] = best_ff;
                  remain_in         = remain_ff - AW'(best_ff);
                  state_in          = (remain_ff == AW'(best_ff)) ? S_OUT : S_SCAN;
               end
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               if (idx_last) begin
                  idx_in   = '0;
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + CI_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Register writes restart the cell load
      if (csr_take) begin
         unique case (csr_index)
            gcd_pkg::REG_CORNER_COUNT: begin
               corner_count_in = csr_data[CC_W-1:0];
               load_cnt_in     = '0;
            end
            gcd_pkg::REG_INNER_COUNT: begin
               inner_count_in = csr_data[IC_W-1:0];
               load_cnt_in    = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         corner_count_ff <= gcd_pkg::CORNER_COUNT_RESET;
         inner_count_ff  <= gcd_pkg::INNER_COUNT_RESET;
         load_cnt_ff     <= '0;
         idx_ff          <= '0;
         remain_ff       <= '0;
         found_ff        <= 1'b0;
         delta_ff        <= '0;
         chosen_ff       <= '0;
      end else begin
         state_ff        <= state_in;
         corner_count_ff <= corner_count_in;
         inner_count_ff  <= inner_count_in;
         load_cnt_ff     <= load_cnt_in;
         idx_ff          <= idx_in;
         remain_ff       <= remain_in;
         found_ff        <= found_in;
         delta_ff        <= delta_in;
         chosen_ff       <= chosen_in;
      end
   end

   // Search payload
   always_ff @(posedge clock) begin
      best_ff <= best_in;
      pick_ff <= pick_in;
      avg_ff  <= avg_in;
   end

   // Result items, one per corner in order
   assign rsp_valid         = (state_ff == S_OUT);
   assign rsp_corner_number = gcd_pkg::NUMBER_W'(idx_ff);
   assign rsp_corner_delta  = delta_ff[idx_ff];
   assign rsp_last          = idx_last;

endmodule
